@@ rtl/periodic_timer_table_assert.svh @@
// Assertion macros shared by the timer table modules.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PTT_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define PTT_ASSERT(label, clk, rstn, prop, msg)
`define PTT_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

@@ rtl/ptt_pkg.sv @@
// Shared types and constants of the periodic timer table.
package ptt_pkg;
  localparam int unsigned TimerSlotsDef = 16;
  localparam int unsigned TimeWidthDef  = 32;

  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_SCHEDULE = 2'd1;
  localparam logic [1:0] KIND_RELEASE  = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam logic [1:0] RES_ASSIGNED = 2'd0;
  localparam logic [1:0] RES_FIRED    = 2'd1;
  localparam logic [1:0] RES_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] elapsed;
    logic [7:0]  priority_req;
    logic [31:0] period;
    logic [15:0] release_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] timer_id;
    logic        last;
  } res_t;
endpackage

@@ rtl/ptt_if.sv @@
// Valid/ready channel interfaces for commands and results.
interface ptt_cmd_if import ptt_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0]  kind;
  logic [31:0] elapsed;
  logic [7:0]  priority_req;
  logic [31:0] period;
  logic [15:0] release_id;
  modport source (output valid, kind, elapsed, priority_req, period, release_id,
                  input ready);
  modport sink (input valid, kind, elapsed, priority_req, period, release_id,
                output ready);
endinterface

interface ptt_res_if import ptt_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0]  result_kind;
  logic [15:0] timer_id;
  logic        last;
  modport source (output valid, result_kind, timer_id, last, input ready);
  modport sink (input valid, result_kind, timer_id, last, output ready);
endinterface

@@ rtl/ptt_front.sv @@
// Front end: accept commands, drop unknown kinds, push into a two-entry queue.
`include "periodic_timer_table_assert.svh"
module ptt_front import ptt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ptt_cmd_if.sink cmd,
  output logic q_valid_o,
  output cmd_t q_cmd_o,
  input  logic q_pop_i
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign cmd.ready = (cnt_q != 2'd2);
  assign push = cmd.valid && cmd.ready && (cmd.kind != KIND_UNUSED);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{cmd.kind, cmd.elapsed, cmd.priority_req, cmd.period,
                       cmd.release_id};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  `PTT_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(q_pop_i && cnt_q == 2'd0),
              "pop from empty queue")
  `PTT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count overflow")
  `PTT_ASSERT_NEXT(a_full_block, clk_i, rst_ni, cnt_q == 2'd2 && !q_pop_i,
                   cnt_q == 2'd2, "full queue lost an entry")
endmodule

@@ rtl/ptt_back.sv @@
// Back end: table store, ordered insert, release mark, tick walk with serial remainder.
`include "periodic_timer_table_assert.svh"
module ptt_back import ptt_pkg::*; #(
  parameter int unsigned TimerSlots = TimerSlotsDef,
  parameter int unsigned TimeWidth  = TimeWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  ptt_res_if.source res
);
  localparam int unsigned IW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned AW = TimeWidth + 1;
  localparam int unsigned BW = $clog2(AW + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_ADD = 3'd1, S_DIV = 3'd2,
                         S_EMIT = 3'd3, S_NEXT = 3'd4, S_COMPACT = 3'd5,
                         S_OUT = 3'd6;

  logic [TimerSlots-1:0] valid_q, pend_q;
  logic [15:0]          id_q  [TimerSlots];
  logic [7:0]           pri_q [TimerSlots];
  logic [TimeWidth-1:0] per_q [TimerSlots];
  logic [AW-1:0]        acc_q [TimerSlots];
  logic [15:0] idc_q;
  logic [2:0]  st_q;
  logic [IW-1:0] idx_q;
  logic [AW-1:0] rem_q;
  logic [BW-1:0] bit_q;
  logic [TimeWidth-1:0] el_q;
  res_t          out_q;
  logic          out_v_q;

  logic full;
  logic [15:0] new_id;
  logic [TimerSlots-1:0] ge, lt, lt_prev;
  logic [AW-1:0] sum;
  logic          fire_any;

  assign full = valid_q[TimerSlots-1];
  assign new_id = (idc_q == 16'hFFFF) ? 16'd1 : idc_q + 16'd1;
  always_comb begin
    for (int i = 0; i < TimerSlots; i++) ge[i] = valid_q[i] && (pri_q[i] >= q_cmd_i.priority_req);
  end
  // slots strictly before the insert point of a new timer
  assign lt = valid_q & ~ge;
  assign lt_prev = {lt[TimerSlots-2:0], 1'b1};
  assign sum = acc_q[idx_q] + {1'b0, el_q};

  assign res.valid = out_v_q;
  assign res.result_kind = out_q.result_kind;
  assign res.timer_id = out_q.timer_id;
  assign res.last = out_q.last;

  logic busy_out;
  logic out_set;
  assign busy_out = out_v_q && !res.ready;
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i && !busy_out;
  assign out_set = (q_pop_o && q_cmd_i.kind == KIND_SCHEDULE) ||
                   (st_q == S_EMIT && !busy_out);

  // fired flag per slot after add; we look ahead over remaining slots for "last"
  logic [TimerSlots-1:0] will_fire;
  always_comb begin
    for (int i = 0; i < TimerSlots; i++) begin
      will_fire[i] = valid_q[i] && (acc_q[i] + {1'b0, el_q} >= {1'b0, per_q[i]});
    end
    fire_any = 1'b0;
    for (int i = 0; i < TimerSlots; i++) begin
      if (will_fire[i] && i > int'(idx_q)) fire_any = 1'b1;
    end
  end

  logic [IW-1:0] wr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; pend_q <= '0; idc_q <= '0; st_q <= S_IDLE;
      out_v_q <= 1'b0; idx_q <= '0; wr_q <= '0;
    end else begin
      if (out_set) out_v_q <= 1'b1;
      else if (res.ready) out_v_q <= 1'b0;
      case (st_q)
        S_IDLE: if (q_pop_o) begin
          case (q_cmd_i.kind)
            KIND_TICK: begin
              el_q <= TimeWidth'(q_cmd_i.elapsed);
              idx_q <= '0; wr_q <= '0;
              st_q <= valid_q[0] ? S_ADD : S_IDLE;
            end
            KIND_SCHEDULE: begin
              out_q.last <= 1'b1;
              if (full) begin
                out_q.result_kind <= RES_FULL; out_q.timer_id <= '0;
              end else begin
                out_q.result_kind <= RES_ASSIGNED; out_q.timer_id <= new_id;
                idc_q <= new_id;
                // enter the new timer at the first slot not before it
                for (int i = 0; i < TimerSlots; i++) begin
                  if (!lt[i] && lt_prev[i]) begin
                    id_q[i] <= new_id; pri_q[i] <= q_cmd_i.priority_req;
                    per_q[i] <= TimeWidth'(q_cmd_i.period); acc_q[i] <= '0;
                    pend_q[i] <= 1'b0;
                  end
                end
                // move every later slot up by one
                for (int i = 1; i < TimerSlots; i++) begin
                  if (!lt[i] && !lt_prev[i]) begin
                    id_q[i] <= id_q[i-1]; pri_q[i] <= pri_q[i-1];
                    per_q[i] <= per_q[i-1]; acc_q[i] <= acc_q[i-1];
                    pend_q[i] <= pend_q[i-1];
                  end
                end
                valid_q <= {valid_q[TimerSlots-2:0], 1'b1};
              end
            end
            KIND_RELEASE: begin
              for (int i = 0; i < TimerSlots; i++)
                if (valid_q[i] && id_q[i] == q_cmd_i.release_id) pend_q[i] <= 1'b1;
            end
            default: ;
          endcase
        end
        S_ADD: begin
          if (sum >= {1'b0, per_q[idx_q]}) begin
            if (per_q[idx_q] == '0) begin
              acc_q[idx_q] <= '0; st_q <= S_EMIT;
            end else begin
              rem_q <= '0; bit_q <= BW'(AW);
              acc_q[idx_q] <= sum; st_q <= S_DIV;
            end
          end else begin
            acc_q[idx_q] <= sum; st_q <= S_NEXT;
          end
        end
        S_DIV: begin
          // restoring remainder, one dividend bit per cycle
          if (bit_q == '0) begin
            acc_q[idx_q] <= rem_q; st_q <= S_EMIT;
          end else begin
            logic [AW:0] t;
            t = {rem_q, acc_q[idx_q][bit_q-1]};
            if (t >= {2'b0, per_q[idx_q]}) rem_q <= AW'(t - {2'b0, per_q[idx_q]});
            else rem_q <= t[AW-1:0];
            bit_q <= bit_q - 1'b1;
          end
        end
        S_EMIT: if (!busy_out) begin
          out_q.result_kind <= RES_FIRED; out_q.timer_id <= id_q[idx_q];
          out_q.last <= !fire_any;
          st_q <= S_NEXT;
        end
        S_NEXT: begin
          if (idx_q == IW'(TimerSlots-1) || !valid_q[idx_q+1'b1]) begin
            idx_q <= '0; wr_q <= '0; st_q <= S_COMPACT;
          end else begin
            idx_q <= idx_q + 1'b1; st_q <= S_ADD;
          end
        end
        S_COMPACT: begin
          if (valid_q[idx_q] && !pend_q[idx_q]) begin
            id_q[wr_q] <= id_q[idx_q]; pri_q[wr_q] <= pri_q[idx_q];
            per_q[wr_q] <= per_q[idx_q]; acc_q[wr_q] <= acc_q[idx_q];
            wr_q <= wr_q + 1'b1;
          end
          if (idx_q == IW'(TimerSlots-1) || !valid_q[idx_q]) begin
            for (int i = 0; i < TimerSlots; i++) begin
              valid_q[i] <= (i < int'(wr_q) + ((valid_q[idx_q] && !pend_q[idx_q]) ? 1 : 0));
            end
            // kept timers were unmarked, released ones are gone
            pend_q <= '0;
            st_q <= S_IDLE;
          end else idx_q <= idx_q + 1'b1;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `PTT_ASSERT(a_valid_packed, clk_i, rst_ni,
              ((valid_q + 1'b1) & valid_q) == '0, "valid slots not contiguous")
  `PTT_ASSERT(a_pend_valid, clk_i, rst_ni, (pend_q & ~valid_q) == '0,
              "release mark on empty slot")
  `PTT_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_v_q && !res.ready,
                   out_v_q && $stable(out_q), "result changed while stalled")
endmodule

@@ rtl/periodic_timer_table.sv @@
// Top level of the periodic timer table.
// A table of up to TimerSlots periodic timers kept in firing order (ascending
// priority, newest first among equals). Schedule returns a new id or reports
// full; release marks a timer, removed after the next tick; tick adds elapsed
// time to each accumulator and reports each timer that reached its period.
// Commands enter a two-entry queue, so one waits while the back end works.
// Schedule and release are handled in the idle state of the back end. A tick
// walks the valid slots one at a time: it adds elapsed time to each slot, runs
// a bit-serial remainder for a firing slot with nonzero period and emits a
// result for each firing slot, waiting while the result register stays
// stalled; then a pass over the valid slots, and one slot more when the
// table is not full, compacts away released timers. Results leave through a
// registered output.
module periodic_timer_table import ptt_pkg::*; #(
  parameter int unsigned TimerSlots = TimerSlotsDef,
  parameter int unsigned TimeWidth  = TimeWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  ptt_cmd_if.sink   cmd,
  ptt_res_if.source res
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // accept and queue commands
  ptt_front u_front (
    .clk_i, .rst_ni, .cmd, .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  // execute commands against the table
  ptt_back #(.TimerSlots(TimerSlots), .TimeWidth(TimeWidth)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop), .res
  );
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the periodic timer table.
module tb_top;
  import ptt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = TimerSlotsDef;

  // Predicts the result transactions of the timer table and checks the actual ones.
  class timer_scoreboard;
    int unsigned used;
    logic [15:0] ids[Slots];
    logic [7:0]  pris[Slots];
    logic [31:0] pers[Slots];
    logic [32:0] accs[Slots];
    bit          marked[Slots];
    logic [15:0] id_count;
    res_t        expected_q[$];
    int          errors;

    function new();
      used = 0;
      id_count = '0;
      errors = 0;
      foreach (marked[i]) marked[i] = 1'b0;
    endfunction

    // Append one predicted result transaction.
    function void add_result(res_t r);
      expected_q = {expected_q, r};
    endfunction

    // Apply one accepted command transaction to the predicted table.
    function void note_cmd(cmd_t c);
      logic [32:0] a;
      logic [15:0] nid;
      int unsigned fired;
      int unsigned w;
      int unsigned pos;
      fired = 0;
      if (c.kind == KIND_TICK) begin
        for (int unsigned i = 0; i < used; i++) begin
          a = accs[i] + {1'b0, c.elapsed};
          if ({1'b0, pers[i]} <= a) begin
            a = (pers[i] == '0) ? '0 : a % {1'b0, pers[i]};
            add_result(res_t'{RES_FIRED, ids[i], 1'b0});
            fired++;
          end
          accs[i] = a;
        end
        if (fired > 0) expected_q[expected_q.size() - 1].last = 1'b1;
        w = 0;
        for (int unsigned i = 0; i < used; i++) begin
          if (!marked[i]) begin
            ids[w] = ids[i];
            pris[w] = pris[i];
            pers[w] = pers[i];
            accs[w] = accs[i];
            marked[w] = 1'b0;
            w++;
          end
        end
        for (int unsigned i = w; i < Slots; i++) marked[i] = 1'b0;
        used = w;
      end else if (c.kind == KIND_SCHEDULE) begin
        if (used >= Slots) begin
          add_result(res_t'{RES_FULL, 16'd0, 1'b1});
        end else begin
          nid = id_count + 16'd1;
          if (nid == '0) nid = 16'd1;
          id_count = nid;
          pos = used;
          for (int unsigned i = 0; i < used; i++) begin
            if (pris[i] >= c.priority_req) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = used; i > pos; i--) begin
            ids[i] = ids[i-1];
            pris[i] = pris[i-1];
            pers[i] = pers[i-1];
            accs[i] = accs[i-1];
            marked[i] = marked[i-1];
          end
          ids[pos] = nid;
          pris[pos] = c.priority_req;
          pers[pos] = c.period;
          accs[pos] = '0;
          marked[pos] = 1'b0;
          used++;
          add_result(res_t'{RES_ASSIGNED, nid, 1'b1});
        end
      end else if (c.kind == KIND_RELEASE) begin
        for (int unsigned i = 0; i < used; i++) begin
          if (ids[i] == c.release_id) marked[i] = 1'b1;
        end
      end
      // the unused kind code is dropped by the block
    endfunction

    // Compare one result transaction against the oldest prediction.
    function void check_result(res_t r);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d id %0d last %0d",
               r.result_kind, r.timer_id, r.last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.result_kind !== e.result_kind) begin
        $error("result_kind: expected %0d, actual %0d", e.result_kind, r.result_kind);
        errors++;
      end
      if (r.timer_id !== e.timer_id) begin
        $error("timer_id: expected %0d, actual %0d", e.timer_id, r.timer_id);
        errors++;
      end
      if (r.last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet;        // no idling on either side in the last part of the run
  int   sink_hold;

  ptt_cmd_if cmd ();
  ptt_res_if res ();

  timer_scoreboard sb;

  periodic_timer_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd),
    .res    (res)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop: far above the slowest correct run (every tick firing all slots
  // while the sink stalls on each result).
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: random stall bursts, sampled at the rising edge.
  initial begin
    res.ready = 1'b0;
    sink_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        res.ready = 1'b0;
        sink_hold--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        res.ready = 1'b0;
        sink_hold = $urandom_range(1, 16) - 1;
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      sb.check_result(res_t'{res.result_kind, res.timer_id, res.last});
    end
  end

  // Offer one command transaction, starting and ending at a falling edge.
  // Valid stays high afterwards; the next call or the caller decides.
  task automatic drive_cmd(input cmd_t c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    cmd.valid        = 1'b1;
    cmd.kind         = c.kind;
    cmd.elapsed      = c.elapsed;
    cmd.priority_req = c.priority_req;
    cmd.period       = c.period;
    cmd.release_id   = c.release_id;
    do @(posedge clk_i); while (!cmd.ready);
    sb.note_cmd(c);
    @(negedge clk_i);
  endtask

  task automatic schedule(input logic [7:0] pri, input logic [31:0] per);
    drive_cmd('{KIND_SCHEDULE, $urandom(), pri, per, 16'($urandom())});
  endtask

  task automatic tick(input logic [31:0] el);
    drive_cmd('{KIND_TICK, el, 8'($urandom()), $urandom(), 16'($urandom())});
  endtask

  task automatic release_timer(input logic [15:0] id);
    drive_cmd('{KIND_RELEASE, $urandom(), 8'($urandom()), $urandom(), id});
  endtask

  // Build one random command transaction, weighted toward live timers.
  task automatic random_cmd();
    int unsigned sel;
    logic [31:0] per;
    logic [31:0] el;
    logic [7:0]  pri;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      case ($urandom_range(0, 9))
        0: per = $urandom();
        1, 2: per = $urandom_range(1, 5000);
        default: per = $urandom_range(1, 64);
      endcase
      pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      schedule(pri, per);
    end else if (sel < 75) begin
      el = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 100);
      tick(el);
    end else if (sel < 95) begin
      if (sb.used > 0 && $urandom_range(0, 9) < 7) begin
        release_timer(sb.ids[$urandom_range(0, sb.used - 1)]);
      end else begin
        release_timer(16'($urandom()));
      end
    end else begin
      drive_cmd('{KIND_UNUSED, $urandom(), 8'($urandom()), $urandom(), 16'($urandom())});
    end
  endtask

  initial begin
    int waited;
    sb = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    cmd.valid = 1'b0;
    cmd.kind = KIND_TICK;
    cmd.elapsed = '0;
    cmd.priority_req = '0;
    cmd.period = '0;
    cmd.release_id = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: tick on an empty table, fill it, overflow it, then
    // releases (known, unknown, repeated), the unused kind and extreme ticks.
    tick(32'd5);
    schedule(8'd255, 32'hFFFF_FFFF);
    schedule(8'd0, 32'd0);          // zero period fires on every tick
    schedule(8'd0, 32'd1);          // equal priority: newest goes first
    for (int i = 0; i < 13; i++) schedule(8'($urandom_range(0, 255)), 32'($urandom_range(1, 40)));
    schedule(8'd7, 32'd3);          // table full
    release_timer(16'd2);
    release_timer(16'd2);           // marking again changes nothing
    release_timer(16'hFFFF);        // unknown id
    schedule(8'd9, 32'd9);          // still full: marked slot stays until tick
    drive_cmd('{KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF});
    tick(32'hFFFF_FFFF);            // every slot fires
    tick(32'd0);
    tick(32'hFFFF_FFFF);

    // Random part; hold the sender once until the table has drained its results.
    for (int n = 0; n < 430; n++) begin
      if (n == 200) begin
        cmd.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk_i);
      end
      if (n == 370) quiet = 1'b1;
      // keep the table busy: refill when it runs low
      if (sb.used < 4 && $urandom_range(0, 1) == 0) begin
        schedule(8'($urandom()), 32'($urandom_range(1, 50)));
      end else begin
        random_cmd();
      end
    end
    cmd.valid = 1'b0;

    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (1000) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_if.sv
rtl/ptt_front.sv
rtl/ptt_back.sv
rtl/periodic_timer_table.sv
tb/tb_top.sv
